@@ rtl/alternating_bridge_pulse_sequencer_top_macros.svh @@
// assertion macros for the alternating bridge pulse sequencer
// no dependencies; included by the top level
`ifndef ALTERNATING_BRIDGE_PULSE_SEQUENCER_TOP_MACROS_SVH
`define ALTERNATING_BRIDGE_PULSE_SEQUENCER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define ABPS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("abps assertion failed");
`define ABPS_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("abps forbidden condition seen");
`else
`define ABPS_ASSERT(lbl, clk, rst_n, prop)
`define ABPS_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

@@ rtl/abps_pkg.sv @@
// types, constants and sweep table for the alternating bridge pulse sequencer
// no dependencies
package abps_pkg;

  localparam int unsigned LenW     = 8;
  localparam int unsigned StepW    = 4;
  localparam int unsigned TableLen = 12;

  localparam logic [LenW-1:0] PulseLenAReset = 8'd16;
  localparam logic [LenW-1:0] PulseLenBReset = 8'd16;
  localparam logic [LenW-1:0] GapLenReset    = 8'd2;

  typedef enum logic [1:0] {
    RegPulseLenA = 2'd0,
    RegPulseLenB = 2'd1,
    RegGapLen    = 2'd2,
    RegSweepMode = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [LenW-1:0] len_a;
    logic [LenW-1:0] len_b;
    logic [LenW-1:0] gap;
  } sweep_entry_t;

  function automatic sweep_entry_t sweep_entry(input logic [StepW-1:0] idx);
    sweep_entry_t e;
    case (idx)
      4'd0:    e = '{len_a: 8'd1,  len_b: 8'd2,  gap: 8'd26};
      4'd1:    e = '{len_a: 8'd4,  len_b: 8'd5,  gap: 8'd24};
      4'd2:    e = '{len_a: 8'd7,  len_b: 8'd8,  gap: 8'd12};
      4'd3:    e = '{len_a: 8'd7,  len_b: 8'd8,  gap: 8'd12};
      4'd4:    e = '{len_a: 8'd10, len_b: 8'd8,  gap: 8'd12};
      4'd5:    e = '{len_a: 8'd10, len_b: 8'd8,  gap: 8'd12};
      4'd6:    e = '{len_a: 8'd8,  len_b: 8'd8,  gap: 8'd14};
      4'd7:    e = '{len_a: 8'd8,  len_b: 8'd8,  gap: 8'd14};
      4'd8:    e = '{len_a: 8'd8,  len_b: 8'd8,  gap: 8'd14};
      4'd9:    e = '{len_a: 8'd19, len_b: 8'd18, gap: 8'd20};
      4'd10:   e = '{len_a: 8'd14, len_b: 8'd11, gap: 8'd20};
      4'd11:   e = '{len_a: 8'd11, len_b: 8'd7,  gap: 8'd34};
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

@@ rtl/alternating_bridge_pulse_sequencer_top.sv @@
// alternating two-phase bridge pulse sequencer, top level
// depends on abps_pkg and alternating_bridge_pulse_sequencer_top_macros.svh
// a tick transaction accepted at one edge shows its registered result on the next cycle
// throughput: one tick per cycle while the output is taken; state update and result register in a single pass
// the result register frees as it is taken, so input stalls only on a held output
// reset (async, active low) restores register defaults and the sequencer state
`include "alternating_bridge_pulse_sequencer_top_macros.svh"

module alternating_bridge_pulse_sequencer_top #(
  parameter int unsigned SWEEP_STEPS = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [0] drive, [7:1] zero
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [0] phase_a_on, [1] phase_b_on,
                                       // [5:2] sweep_step, [6] swapped, [7] zero
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  localparam int unsigned IdxW = abps_pkg::StepW + 1;

  logic [abps_pkg::LenW-1:0]  pulse_len_a_q, pulse_len_b_q, gap_len_q;
  logic                       sweep_mode_q;
  logic [abps_pkg::LenW-1:0]  count_a_q, count_a_d, count_b_q, count_b_d;
  logic [abps_pkg::LenW-1:0]  gap_count_q, gap_count_d;
  logic                       next_is_a_q, next_is_a_d;
  logic [abps_pkg::StepW-1:0] sweep_index_q, sweep_index_d;
  logic                       swap_flag_q, swap_flag_d;
  logic [abps_pkg::LenW-1:0]  work_len_a_q, work_len_a_d;
  logic [abps_pkg::LenW-1:0]  work_len_b_q, work_len_b_d;
  logic [abps_pkg::LenW-1:0]  work_gap_q, work_gap_d;
  logic [abps_pkg::LenW-1:0]  pulse_len_a_d, pulse_len_b_d, gap_len_d;
  logic                       sweep_mode_d;

  logic                       out_valid_q;
  logic                       phase_a_q, phase_a_d, phase_b_q, phase_b_d;

  logic                       in_acc, cfg_acc, drive;
  logic [abps_pkg::LenW-1:0]  gap_inc, load_len;
  logic [IdxW-1:0]            idx_inc;
  logic [abps_pkg::StepW-1:0] idx_new;
  logic                       swap_new;
  abps_pkg::sweep_entry_t     entry;
  logic [abps_pkg::LenW-1:0]  sw_len_a, sw_len_b, sw_gap;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign cfg_ready_o     = 1'b1;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_acc         = cfg_valid_i && cfg_ready_o;
  assign drive           = s_axis_tdata_i[0];

  assign gap_inc  = gap_count_q + 8'd1;
  assign idx_inc  = {1'b0, sweep_index_q} + IdxW'(1);
  assign idx_new  = (idx_inc >= IdxW'(SWEEP_STEPS)) ? '0 : idx_inc[abps_pkg::StepW-1:0];
  assign swap_new = (idx_inc >= IdxW'(SWEEP_STEPS)) ? !swap_flag_q : swap_flag_q;
  assign entry    = abps_pkg::sweep_entry(idx_new);

  always_comb begin
    if (idx_new < abps_pkg::StepW'(abps_pkg::TableLen)) begin
      sw_len_a = entry.len_a;
      sw_len_b = entry.len_b;
      sw_gap   = entry.gap;
    end else begin
      sw_len_a = work_len_a_q;
      sw_len_b = work_len_b_q;
      sw_gap   = work_gap_q;
    end
  end

  always_comb begin
    count_a_d     = count_a_q;
    count_b_d     = count_b_q;
    gap_count_d   = gap_count_q;
    next_is_a_d   = next_is_a_q;
    sweep_index_d = sweep_index_q;
    swap_flag_d   = swap_flag_q;
    work_len_a_d  = work_len_a_q;
    work_len_b_d  = work_len_b_q;
    work_gap_d    = work_gap_q;
    phase_a_d     = 1'b0;
    phase_b_d     = 1'b0;
    load_len      = '0;
    if (in_acc && drive) begin
      if (count_a_q != '0) begin
        count_a_d   = count_a_q - 8'd1;
        count_b_d   = '0;
        gap_count_d = '0;
        phase_a_d   = 1'b1;
      end else if (count_b_q != '0) begin
        count_b_d   = count_b_q - 8'd1;
        count_a_d   = '0;
        gap_count_d = '0;
        phase_b_d   = 1'b1;
      end else begin
        gap_count_d = gap_inc;
        if (gap_inc >= work_gap_q) begin
          if (sweep_mode_q) begin
            sweep_index_d = idx_new;
            swap_flag_d   = swap_new;
            work_len_a_d  = sw_len_a;
            work_len_b_d  = sw_len_b;
            work_gap_d    = sw_gap;
            load_len      = swap_new ? sw_len_b : sw_len_a;
          end else begin
            load_len = next_is_a_q ? work_len_a_q : work_len_b_q;
          end
          if (next_is_a_q) begin
            count_a_d   = load_len;
            next_is_a_d = 1'b0;
          end else begin
            count_b_d   = load_len;
            next_is_a_d = 1'b1;
          end
        end
      end
    end

    pulse_len_a_d = pulse_len_a_q;
    pulse_len_b_d = pulse_len_b_q;
    gap_len_d     = gap_len_q;
    sweep_mode_d  = sweep_mode_q;
    if (cfg_acc) begin
      unique case (abps_pkg::reg_idx_e'(cfg_index_i))
        abps_pkg::RegPulseLenA: pulse_len_a_d = cfg_data_i;
        abps_pkg::RegPulseLenB: pulse_len_b_d = cfg_data_i;
        abps_pkg::RegGapLen:    gap_len_d     = cfg_data_i;
        abps_pkg::RegSweepMode: sweep_mode_d  = cfg_data_i[0];
        default:                sweep_mode_d  = sweep_mode_q;
      endcase
      work_len_a_d = pulse_len_a_d;
      work_len_b_d = pulse_len_b_d;
      work_gap_d   = gap_len_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_len_a_q <= abps_pkg::PulseLenAReset;
      pulse_len_b_q <= abps_pkg::PulseLenBReset;
      gap_len_q     <= abps_pkg::GapLenReset;
      sweep_mode_q  <= 1'b0;
      count_a_q     <= 8'd16;
      count_b_q     <= 8'd16;
      gap_count_q   <= '0;
      next_is_a_q   <= 1'b0;
      sweep_index_q <= '0;
      swap_flag_q   <= 1'b0;
      work_len_a_q  <= abps_pkg::PulseLenAReset;
      work_len_b_q  <= abps_pkg::PulseLenBReset;
      work_gap_q    <= abps_pkg::GapLenReset;
      out_valid_q   <= 1'b0;
    end else begin
      pulse_len_a_q <= pulse_len_a_d;
      pulse_len_b_q <= pulse_len_b_d;
      gap_len_q     <= gap_len_d;
      sweep_mode_q  <= sweep_mode_d;
      count_a_q     <= count_a_d;
      count_b_q     <= count_b_d;
      gap_count_q   <= gap_count_d;
      next_is_a_q   <= next_is_a_d;
      sweep_index_q <= sweep_index_d;
      swap_flag_q   <= swap_flag_d;
      work_len_a_q  <= work_len_a_d;
      work_len_b_q  <= work_len_b_d;
      work_gap_q    <= work_gap_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded with each tick transaction
  logic [abps_pkg::StepW-1:0] step_q;
  logic                       swapped_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      phase_a_q <= phase_a_d;
      phase_b_q <= phase_b_d;
      step_q    <= sweep_index_d;
      swapped_q <= swap_flag_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, swapped_q, step_q, phase_b_q, phase_a_q};

  `ABPS_ASSERT_NEVER(a_phases_exclusive, clk_i, rst_ni, out_valid_q && phase_a_q && phase_b_q)
  `ABPS_ASSERT(a_step_in_range, clk_i, rst_ni, {1'b0, sweep_index_q} < IdxW'(SWEEP_STEPS))
  `ABPS_ASSERT(a_hold_tick_off, clk_i, rst_ni, (in_acc && !drive) |=> (!phase_a_q && !phase_b_q))
  `ABPS_ASSERT(a_one_pulse_count, clk_i, rst_ni, (in_acc && drive && (count_a_q != '0)) |=> (count_b_q == '0))

endmodule
